### hw/rtl/omdx_pkg.sv
// ----------------------------------------------------------------------------
// omdx_pkg: output channel mixdown shared definitions
// Field widths, opcodes, register indexes, speaker layout tables and the
// structs that pass between the controller, datapath and register block.
// ----------------------------------------------------------------------------
`default_nettype none

package omdx_pkg;

	localparam int unsigned NUM_CHANNELS_DEF = 9;
	localparam int unsigned SAMPLE_BITS_DEF  = 24;
	localparam int unsigned COEFF_BITS_DEF   = 16;

	localparam int unsigned OP_W       = 2;
	localparam int unsigned CH_W       = 4;
	localparam int unsigned VAL_W      = 24;
	localparam int unsigned LAYOUT_W   = 3;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned SLOT_W     = 4;
	localparam int unsigned SLOT_MAP_W = 36;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 36;
	localparam int unsigned OUT_W      = 32;
	localparam int unsigned SPK_W      = 3;
	localparam int unsigned NSPK_W     = 4;

	localparam int unsigned COEFF_FRAC = 14;
	localparam int unsigned FIX_FRAC   = 20;
	localparam int unsigned GAIN_SHIFT = 15;
	localparam int          SAMPLE_ONE = 1048576;
	localparam logic [15:0] S16_MIN    = 16'h8000;
	localparam logic [15:0] S16_MAX    = 16'h7fff;

	typedef enum logic [OP_W-1:0] {
		OP_COEFF  = 2'd0,
		OP_CLICK  = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_EOB    = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KIND   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_U8  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_S16 = 2'd1;

	localparam logic [LAYOUT_W-1:0] LAYOUT_STEREO = 3'd1;

	localparam logic [CH_W-1:0] SPK_FL  = 4'd0;
	localparam logic [CH_W-1:0] SPK_FR  = 4'd1;
	localparam logic [CH_W-1:0] SPK_FC  = 4'd2;
	localparam logic [CH_W-1:0] SPK_LFE = 4'd3;
	localparam logic [CH_W-1:0] SPK_BL  = 4'd4;
	localparam logic [CH_W-1:0] SPK_BR  = 4'd5;
	localparam logic [CH_W-1:0] SPK_BC  = 4'd6;
	localparam logic [CH_W-1:0] SPK_SL  = 4'd7;
	localparam logic [CH_W-1:0] SPK_SR  = 4'd8;

	// mono, stereo, quad, 5.1, 6.1, 7.1, two unused codes
	localparam logic [NSPK_W-1:0] LAYOUT_LEN [8] = '{
		4'd1, 4'd2, 4'd4, 4'd6, 4'd7, 4'd8, 4'd0, 4'd0
	};

	localparam logic [CH_W-1:0] LAYOUT_CHAN [8][8] = '{
		'{SPK_FC, SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL},
		'{SPK_FL, SPK_FR, SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL},
		'{SPK_FL, SPK_FR, SPK_BL, SPK_BR, SPK_FL, SPK_FL, SPK_FL, SPK_FL},
		'{SPK_FL, SPK_FR, SPK_FC, SPK_LFE, SPK_BL, SPK_BR, SPK_FL, SPK_FL},
		'{SPK_FL, SPK_FR, SPK_FC, SPK_LFE, SPK_BC, SPK_SL, SPK_SR, SPK_FL},
		'{SPK_FL, SPK_FR, SPK_FC, SPK_LFE, SPK_BL, SPK_BR, SPK_SL, SPK_SR},
		'{SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL},
		'{SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL, SPK_FL}
	};

	typedef struct packed {
		op_t                     opcode;
		logic [CH_W-1:0]         channel;
		logic [CH_W-1:0]         dest_channel;
		logic signed [VAL_W-1:0] value;
		logic                    frame_last;
	} item_t;

	typedef struct packed {
		logic [LAYOUT_W-1:0]   layout;
		logic [KIND_W-1:0]     kind;
		logic [SLOT_MAP_W-1:0] slot_map;
	} cfg_t;

	typedef struct packed {
		logic            take;
		logic            frame_clr;
		logic            mac_clr;
		logic            rd_start;
		logic            issue;
		logic            conv;
		logic            put;
		logic            last;
		logic [CH_W-1:0] c;
		logic [CH_W-1:0] spk;
	} ctl_cmd_t;

	typedef struct packed {
		logic s1_empty;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/omdx_ifs.sv
// ----------------------------------------------------------------------------
// omdx_ifs: mixdown channel interfaces
// Command word channel, configuration write channel and result word channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface omdx_cmd_if import omdx_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         opcode;
	logic [CH_W-1:0]         channel;
	logic [CH_W-1:0]         dest_channel;
	logic signed [VAL_W-1:0] value;
	logic                    frame_last;

	modport source (
		output valid, opcode, channel, dest_channel, value, frame_last,
		input  ready
	);
	modport sink (
		input  valid, opcode, channel, dest_channel, value, frame_last,
		output ready
	);
endinterface

interface omdx_cfg_if import omdx_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface omdx_mix_if import omdx_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] sample;
	logic [SLOT_W-1:0]       slot;
	logic                    last;

	modport source (output valid, sample, slot, last, input ready);
	modport sink (input valid, sample, slot, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/omdx_ram.sv
// ----------------------------------------------------------------------------
// omdx_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module omdx_ram #(
	parameter int unsigned WIDTH  = 16,
	parameter int unsigned DEPTH  = 81,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/omdx_regs.sv
// ----------------------------------------------------------------------------
// omdx_regs: mixdown configuration registers
// Speaker layout, output sample kind and device slot map.
// ----------------------------------------------------------------------------
`default_nettype none

module omdx_regs import omdx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	omdx_cfg_if.sink   cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.layout   <= LAYOUT_STEREO;
			regs_q.kind     <= KIND_S16;
			regs_q.slot_map <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LAYOUT: regs_q.layout   <= cfg.data[LAYOUT_W-1:0];
				REG_KIND:   regs_q.kind     <= cfg.data[KIND_W-1:0];
				REG_SLOTS:  regs_q.slot_map <= cfg.data[SLOT_MAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/omdx_ctl.sv
// ----------------------------------------------------------------------------
// omdx_ctl: mixdown controller
// Accepts command words and sequences the per-speaker multiply-accumulate,
// conversion and result hand-off in the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module omdx_ctl import omdx_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  item_t    item,
	input  cfg_t     regs,
	input  dp_sts_t  sts,
	output ctl_cmd_t ctrl
);

	localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_ISSUE = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_CONV  = 6'b010000,
		ST_PUT   = 6'b100000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [SPK_W-1:0]  j_q;
	logic [SPK_W-1:0]  j_d;
	logic [CW-1:0]     c_q;
	logic [CW-1:0]     c_d;
	logic [NSPK_W-1:0] n_spk;
	logic [CH_W-1:0]   spk;
	logic              take;
	logic              is_last;

	assign cmd_ready = (state_q == ST_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign n_spk     = LAYOUT_LEN[regs.layout];
	assign spk       = LAYOUT_CHAN[regs.layout][j_q];
	assign is_last   = ({1'b0, j_q} == (n_spk - NSPK_W'(1)));

	always_comb begin
		state_d        = state_q;
		j_d            = j_q;
		c_d            = c_q;
		ctrl           = '0;
		ctrl.take      = take;
		ctrl.c         = CH_W'(c_q);
		ctrl.spk       = spk;
		ctrl.last      = is_last;
		case (state_q)
			ST_IDLE: begin
				if (take && item.opcode == OP_SAMPLE && item.frame_last) begin
					j_d     = '0;
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (n_spk == '0) begin
					ctrl.frame_clr = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					ctrl.mac_clr  = 1'b1;
					ctrl.rd_start = 1'b1;
					c_d           = '0;
					state_d       = (spk < CH_W'(NUM_CHANNELS)) ? ST_ISSUE : ST_DRAIN;
				end
			end
			ST_ISSUE: begin
				ctrl.issue = 1'b1;
				if (c_q == CW'(NUM_CHANNELS - 1)) begin
					state_d = ST_DRAIN;
				end else begin
					c_d = c_q + CW'(1);
				end
			end
			ST_DRAIN: begin
				if (sts.s1_empty) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				ctrl.conv = 1'b1;
				state_d   = ST_PUT;
			end
			ST_PUT: begin
				if (sts.out_free) begin
					ctrl.put = 1'b1;
					if (is_last) begin
						ctrl.frame_clr = 1'b1;
						state_d        = ST_IDLE;
					end else begin
						j_d     = j_q + SPK_W'(1);
						state_d = ST_START;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			c_q     <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			c_q     <= c_d;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/omdx_dp.sv
// ----------------------------------------------------------------------------
// omdx_dp: mixdown datapath
// Click removal and frame store, coefficient RAM, shared multiply-accumulate,
// output format conversion and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module omdx_dp import omdx_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int unsigned SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int unsigned COEFF_BITS   = COEFF_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  cfg_t       regs,
	input  ctl_cmd_t   ctrl,
	output dp_sts_t    sts,
	omdx_mix_if.source mix
);

	localparam int unsigned SB    = SAMPLE_BITS;
	localparam int unsigned CB    = COEFF_BITS;
	localparam int unsigned CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned DEPTH = NUM_CHANNELS * NUM_CHANNELS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned EW    = ((SB > VAL_W) ? SB : VAL_W) + 1;
	localparam int unsigned PW    = SB + CB;
	localparam int unsigned ACCW  = PW + 4;
	localparam int unsigned TW    = ACCW - COEFF_FRAC;
	localparam int unsigned QW    = (TW > FIX_FRAC + 2) ? TW : FIX_FRAC + 2;
	localparam int unsigned XW    = (QW > OUT_W) ? QW : OUT_W + 1;
	localparam int unsigned MW    = FIX_FRAC + GAIN_SHIFT + 2;

	localparam logic signed [QW-1:0] Q_ONE  = QW'(SAMPLE_ONE);
	localparam logic signed [QW-1:0] Q_MONE = -Q_ONE;

	function automatic logic signed [SB-1:0] sat_sb(input logic signed [EW-1:0] x);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &x[EW-1:SB-1];
		hi_zeros = ~|x[EW-1:SB-1];
		if (hi_ones || hi_zeros) begin
			return x[SB-1:0];
		end else if (x[EW-1]) begin
			return {1'b1, {(SB-1){1'b0}}};
		end else begin
			return {1'b0, {(SB-1){1'b1}}};
		end
	endfunction

	logic signed [SB-1:0]   frame_q [NUM_CHANNELS];
	logic signed [SB-1:0]   level_q [NUM_CHANNELS];
	logic signed [SB-1:0]   pend_q  [NUM_CHANNELS];
	logic signed [EW-1:0]   fold_sum [NUM_CHANNELS];

	logic                   ch_ok;
	logic                   dst_ok;
	logic [CW-1:0]          chi;
	logic signed [SB-1:0]   lvl;
	logic signed [SB-1:0]   lvl_dec;
	logic signed [SB-1:0]   lvl_new;
	logic signed [EW-1:0]   frame_sum;
	logic signed [EW-1:0]   pend_sum;
	logic [7:0]             wr_lin;
	logic                   ram_we;
	logic [AW-1:0]          rd_addr_q;
	logic [CB-1:0]          coef_s1;
	logic signed [SB-1:0]   fr_s1;
	logic                   v_s1;
	logic signed [PW-1:0]   prod_s2;
	logic                   v_s2;
	logic signed [ACCW-1:0] acc_q;
	logic signed [ACCW-1:0] acc_sh;
	logic signed [ACCW-1:0] acc_tz;
	logic signed [TW-1:0]   v_tz;
	logic signed [QW-1:0]   v_q;
	logic signed [FIX_FRAC:0] v_in;
	logic signed [MW-1:0]   m_gain;
	logic signed [MW-1:0]   m_tz;
	logic [15:0]            s16;
	logic signed [XW-1:0]   v_x;
	logic [OUT_W-1:0]       sat32;
	logic [OUT_W-1:0]       conv_d;
	logic                   ov_q;
	logic [OUT_W-1:0]       sample_q;
	logic [SLOT_W-1:0]      slot_q;
	logic                   last_q;

	// command decode and click removal
	assign ch_ok   = item.channel < CH_W'(NUM_CHANNELS);
	assign dst_ok  = item.dest_channel < CH_W'(NUM_CHANNELS);
	assign chi     = item.channel[CW-1:0];
	assign lvl     = level_q[chi];
	assign lvl_dec = (lvl >>> 8) + $signed(SB'(lvl[SB-1] && (|lvl[7:0])));
	assign lvl_new = lvl - lvl_dec;
	assign frame_sum = EW'(item.value) + EW'(lvl_new);
	assign pend_sum  = EW'(pend_q[chi]) + EW'(item.value);

	always_comb begin
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			fold_sum[k] = EW'(level_q[k]) + EW'(pend_q[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				frame_q[k] <= '0;
				level_q[k] <= '0;
				pend_q[k]  <= '0;
			end
		end else begin
			if (ctrl.take && item.opcode == OP_CLICK && ch_ok) begin
				pend_q[chi] <= sat_sb(pend_sum);
			end
			if (ctrl.take && item.opcode == OP_EOB) begin
				for (int k = 0; k < NUM_CHANNELS; k++) begin
					level_q[k] <= sat_sb(fold_sum[k]);
					pend_q[k]  <= '0;
				end
			end
			if (ctrl.take && item.opcode == OP_SAMPLE && ch_ok) begin
				level_q[chi] <= lvl_new;
				frame_q[chi] <= sat_sb(frame_sum);
			end
			if (ctrl.frame_clr) begin
				for (int k = 0; k < NUM_CHANNELS; k++) begin
					frame_q[k] <= '0;
				end
			end
		end
	end

	// coefficient matrix, row-major by source channel
	assign wr_lin = 8'(item.channel) * 8'(NUM_CHANNELS) + 8'(item.dest_channel);
	assign ram_we = ctrl.take && item.opcode == OP_COEFF && ch_ok && dst_ok;

	omdx_ram #(
		.WIDTH (CB),
		.DEPTH (DEPTH),
		.ADDR_W(AW)
	) u_coef_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_lin[AW-1:0]),
		.wdata(item.value[CB-1:0]),
		.re   (ctrl.issue),
		.raddr(rd_addr_q),
		.rdata(coef_s1)
	);

	// multiply-accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_start) begin
			rd_addr_q <= AW'(ctrl.spk);
		end else if (ctrl.issue) begin
			rd_addr_q <= rd_addr_q + AW'(NUM_CHANNELS);
		end
		if (ctrl.issue) begin
			fr_s1 <= frame_q[ctrl.c[CW-1:0]];
		end
		prod_s2 <= fr_s1 * $signed(coef_s1);
		if (ctrl.mac_clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACCW'(prod_s2);
		end
		if (ctrl.conv) begin
			v_q <= QW'(v_tz);
		end
	end

	// drop the coefficient fraction, truncating toward zero
	assign acc_sh = acc_q >>> COEFF_FRAC;
	assign acc_tz = acc_sh + ACCW'(acc_q[ACCW-1] && (|acc_q[COEFF_FRAC-1:0]));
	assign v_tz   = acc_tz[TW-1:0];

	// 16-bit scale: v * (2^15 - 1) / 2^20, truncating toward zero
	assign v_in   = v_q[FIX_FRAC:0];
	assign m_gain = (MW'(v_in) <<< GAIN_SHIFT) - MW'(v_in);
	assign m_tz   = (m_gain >>> FIX_FRAC)
		+ $signed(MW'(m_gain[MW-1] && (|m_gain[FIX_FRAC-1:0])));

	always_comb begin
		if (v_q <= Q_MONE) begin
			s16 = S16_MIN;
		end else if (v_q >= Q_ONE) begin
			s16 = S16_MAX;
		end else begin
			s16 = m_tz[15:0];
		end
	end

	assign v_x = XW'(v_q);

	always_comb begin
		if ((&v_x[XW-1:OUT_W-1]) || (~|v_x[XW-1:OUT_W-1])) begin
			sat32 = v_x[OUT_W-1:0];
		end else if (v_x[XW-1]) begin
			sat32 = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sat32 = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	always_comb begin
		case (regs.kind)
			KIND_U8:  conv_d = OUT_W'({~s16[15], s16[14:8]});
			KIND_S16: conv_d = {{(OUT_W-16){s16[15]}}, s16};
			default:  conv_d = sat32;
		endcase
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ctrl.put) begin
			ov_q <= 1'b1;
		end else if (mix.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.put) begin
			sample_q <= conv_d;
			slot_q   <= regs.slot_map[{ctrl.spk, 2'b00} +: SLOT_W];
			last_q   <= ctrl.last;
		end
	end

	assign mix.valid  = ov_q;
	assign mix.sample = sample_q;
	assign mix.slot   = slot_q;
	assign mix.last   = last_q;

	assign sts.s1_empty = !v_s1;
	assign sts.out_free = !ov_q || mix.ready;

endmodule

`default_nettype wire

### hw/rtl/output_channel_mixdown_core.sv
// ----------------------------------------------------------------------------
// output_channel_mixdown_core: output channel mixdown with click removal
// Collects a frame of channel samples with click removal, then emits one
// converted word per speaker of the layout: frame times coefficient matrix.
//
//   channel  dir  word
//   cmd      in   opcode, channel, dest_channel, value, frame_last
//   cfg      in   index, data (speaker layout, sample kind, slot map)
//   mix      out  sample, slot, last
//
// Coefficient, click, end-of-block and non-final sample words leave the
// controller ready for the next word. A final sample word holds off further
// words while the single multiply-accumulate walks the RAM for each speaker.
// Reset clears the click levels, pending clicks and frame; the coefficient
// RAM is not cleared. A stalled mix channel holds the controller at hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module output_channel_mixdown_core import omdx_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int unsigned SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int unsigned COEFF_BITS   = COEFF_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	omdx_cmd_if.sink   cmd,
	omdx_cfg_if.sink   cfg,
	omdx_mix_if.source mix
);

	item_t    item;
	cfg_t     regs;
	ctl_cmd_t ctrl;
	dp_sts_t  sts;

	assign item.opcode       = op_t'(cmd.opcode);
	assign item.channel      = cmd.channel;
	assign item.dest_channel = cmd.dest_channel;
	assign item.value        = cmd.value;
	assign item.frame_last   = cmd.frame_last;

	omdx_regs u_regs (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.regs  (regs)
	);

	omdx_ctl #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd.valid),
		.cmd_ready(cmd.ready),
		.item     (item),
		.regs     (regs),
		.sts      (sts),
		.ctrl     (ctrl)
	);

	omdx_dp #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEFF_BITS  (COEFF_BITS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.regs  (regs),
		.ctrl  (ctrl),
		.sts   (sts),
		.mix   (mix)
	);

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: output channel mixdown core testbench
// Fills the coefficient matrix, then runs a directed sequence of edge cases.
// After that it runs phases of random frames, clicks and coefficient updates,
// one phase per register setting. A built-in mixdown predictor computes the
// expected words, and the monitor compares every mix word field by field.
// The sender and the receiver idle at random in all but the last phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import omdx_pkg::*;

	localparam int NCH          = NUM_CHANNELS_DEF;
	localparam int LIMIT        = 400000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASES       = 10;
	localparam int PHASE_WORDS  = 20;

	typedef struct {
		logic [OUT_W-1:0]  sample;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} mix_word_t;

	logic clk = 1'b0;
	logic arst_n;

	omdx_cmd_if cmd ();
	omdx_cfg_if cfg ();
	omdx_mix_if mix ();

	output_channel_mixdown_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.mix    (mix)
	);

	item_t     cmd_q [$];
	mix_word_t mix_due [$];
	int        send_idle_pct;
	int        recv_idle_pct;
	bit        cmd_took = 1'b0;
	int        err_count = 0;
	int        cycles = 0;

	logic [LAYOUT_W-1:0]              cur_layout;
	logic [KIND_W-1:0]                cur_kind;
	logic [SLOT_MAP_W-1:0]            cur_slots;
	logic signed [COEFF_BITS_DEF-1:0] coef [NCH][NCH];
	longint                           level [NCH];
	longint                           pending [NCH];
	longint                           frame [NCH];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint clamp(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic logic [OUT_W-1:0] format_word(longint v);
		longint s;
		longint r;
		if (v <= -SAMPLE_ONE) s = -32768;
		else if (v >= SAMPLE_ONE) s = 32767;
		else s = (v * 32767) / SAMPLE_ONE;
		case (cur_kind)
			KIND_U8:  r = (s + 32768) / 256;
			KIND_S16: r = s;
			default:  r = clamp(v, OUT_W);
		endcase
		return r[OUT_W-1:0];
	endfunction

	task automatic mixdown_word(input item_t w);
		longint          v;
		longint          acc;
		int              ch;
		int              dst;
		int              n;
		logic [CH_W-1:0] spk;
		mix_word_t       mw;
		v   = $signed(w.value);
		ch  = int'(w.channel);
		dst = int'(w.dest_channel);
		case (w.opcode)
			OP_COEFF: begin
				if (ch < NCH && dst < NCH) coef[ch][dst] = w.value[COEFF_BITS_DEF-1:0];
			end
			OP_CLICK: begin
				if (ch < NCH) pending[ch] = clamp(pending[ch] + v, SAMPLE_BITS_DEF);
			end
			OP_EOB: begin
				for (int c = 0; c < NCH; c++) begin
					level[c]   = clamp(level[c] + pending[c], SAMPLE_BITS_DEF);
					pending[c] = 0;
				end
			end
			default: begin
				if (ch < NCH) begin
					level[ch] -= level[ch] / 256;
					frame[ch] = clamp(v + level[ch], SAMPLE_BITS_DEF);
				end
				if (w.frame_last) begin
					n = int'(LAYOUT_LEN[cur_layout]);
					for (int j = 0; j < n; j++) begin
						spk = LAYOUT_CHAN[cur_layout][j];
						acc = 0;
						for (int c = 0; c < NCH; c++) acc += frame[c] * longint'(coef[c][spk]);
						acc = acc / (longint'(1) <<< COEFF_FRAC);
						mw.sample = format_word(acc);
						mw.slot   = cur_slots[spk*SLOT_W +: SLOT_W];
						mw.last   = (j == n - 1);
						mix_due.push_back(mw);
					end
					for (int c = 0; c < NCH; c++) frame[c] = 0;
				end
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
		err_count++;
	endtask

	function automatic item_t mk_word(op_t op, int ch, int dst, int val, bit fl);
		item_t w;
		w.opcode       = op;
		w.channel      = CH_W'(ch);
		w.dest_channel = CH_W'(dst);
		w.value        = VAL_W'(val);
		w.frame_last   = fl;
		return w;
	endfunction

	function automatic int rand_full();
		return int'($urandom_range(16777215)) - 8388608;
	endfunction

	function automatic int rand_level();
		if ($urandom_range(3) == 0) return rand_full();
		return int'($urandom_range(262143)) - 131072;
	endfunction

	function automatic int rand_coef();
		if ($urandom_range(3) == 0) return rand_full();
		return int'($urandom_range(16383)) - 8192;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_LAYOUT: cur_layout = d[LAYOUT_W-1:0];
			REG_KIND:   cur_kind   = d[KIND_W-1:0];
			REG_SLOTS:  cur_slots  = d[SLOT_MAP_W-1:0];
			default:    ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic settle();
		while (cmd_q.size() != 0 || cmd.valid || mix_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_traffic(input int count);
		int pushed;
		int k;
		int t;
		int last_ch;
		int perm [NCH];
		pushed = 0;
		while (pushed < count) begin
			case ($urandom_range(9))
				0: begin
					cmd_q.push_back(mk_word(op_t'($urandom_range(3)), $urandom_range(15),
						$urandom_range(15), rand_full(), 1'($urandom_range(1))));
					pushed++;
				end
				1: begin
					cmd_q.push_back(mk_word(OP_COEFF, $urandom_range(NCH - 1),
						$urandom_range(NCH - 1), rand_coef(), 1'($urandom_range(1))));
					pushed++;
				end
				default: begin
					if ($urandom_range(2) == 0) begin
						repeat ($urandom_range(3, 1)) begin
							cmd_q.push_back(mk_word(OP_CLICK, $urandom_range(NCH - 1),
								$urandom_range(15), rand_level(), 1'b0));
							pushed++;
						end
						if ($urandom_range(1) == 1) begin
							cmd_q.push_back(mk_word(OP_EOB, 0, $urandom_range(15), rand_full(), 1'b0));
							pushed++;
						end
					end
					for (int i = 0; i < NCH; i++) perm[i] = i;
					for (int i = NCH - 1; i > 0; i--) begin
						t       = $urandom_range(i);
						k       = perm[i];
						perm[i] = perm[t];
						perm[t] = k;
					end
					k = $urandom_range(NCH, 1);
					for (int i = 0; i < k; i++) begin
						last_ch = perm[i];
						if (i == k - 1 && $urandom_range(7) == 0) last_ch = $urandom_range(15, NCH);
						cmd_q.push_back(mk_word(OP_SAMPLE, last_ch, $urandom_range(15),
							rand_level(), i == k - 1));
						pushed++;
					end
				end
			endcase
		end
	endtask

	// capture accepted command words, then check mix words
	always @(posedge clk) begin
		item_t     w;
		mix_word_t want;
		cmd_took = arst_n && cmd.valid && cmd.ready;
		if (cmd_took) begin
			w.opcode       = op_t'(cmd.opcode);
			w.channel      = cmd.channel;
			w.dest_channel = cmd.dest_channel;
			w.value        = cmd.value;
			w.frame_last   = cmd.frame_last;
			mixdown_word(w);
		end
		if (arst_n && mix.valid && mix.ready) begin
			if (mix_due.size() == 0) begin
				report_mismatch("word with none due", 64'(mix.sample), 64'd0);
			end else begin
				want = mix_due.pop_front();
				if (mix.sample !== want.sample) report_mismatch("sample", 64'(mix.sample), 64'(want.sample));
				if (mix.slot !== want.slot) report_mismatch("slot", 64'(mix.slot), 64'(want.slot));
				if (mix.last !== want.last) report_mismatch("last", 64'(mix.last), 64'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		item_t w;
		if (arst_n) begin
			if (!cmd.valid || cmd_took) begin
				if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					w = cmd_q.pop_front();
					cmd.valid        <= 1'b1;
					cmd.opcode       <= w.opcode;
					cmd.channel      <= w.channel;
					cmd.dest_channel <= w.dest_channel;
					cmd.value        <= w.value;
					cmd.frame_last   <= w.frame_last;
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) mix.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		logic [63:0] slot_bits;
		arst_n           = 1'b0;
		cmd.valid        = 1'b0;
		cmd.opcode       = OP_COEFF;
		cmd.channel      = '0;
		cmd.dest_channel = '0;
		cmd.value        = '0;
		cmd.frame_last   = 1'b0;
		cfg.valid        = 1'b0;
		cfg.index        = REG_LAYOUT;
		cfg.data         = '0;
		mix.ready        = 1'b0;
		cur_layout       = LAYOUT_STEREO;
		cur_kind         = KIND_S16;
		cur_slots        = '0;
		for (int c = 0; c < NCH; c++) begin
			level[c]   = 0;
			pending[c] = 0;
			frame[c]   = 0;
			for (int d = 0; d < NCH; d++) coef[c][d] = '0;
		end
		send_idle_pct = 15;
		recv_idle_pct = 68;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// load the whole matrix before any frame reads it
		for (int r = 0; r < NCH; r++)
			for (int c = 0; c < NCH; c++)
				cmd_q.push_back(mk_word(OP_COEFF, r, c, rand_coef(), 1'($urandom_range(1))));

		cmd_q.push_back(mk_word(OP_COEFF, 15, 0, 32767, 1'b0));
		cmd_q.push_back(mk_word(OP_COEFF, 0, 9, 32767, 1'b0));
		cmd_q.push_back(mk_word(OP_COEFF, 0, 0, 32767, 1'b0));
		cmd_q.push_back(mk_word(OP_COEFF, 1, 1, -32768, 1'b0));
		cmd_q.push_back(mk_word(OP_COEFF, 8, 8, 32'h007f1234, 1'b1));
		cmd_q.push_back(mk_word(OP_CLICK, 0, 15, 8388607, 1'b0));
		cmd_q.push_back(mk_word(OP_CLICK, 0, 0, 8388607, 1'b0));
		cmd_q.push_back(mk_word(OP_CLICK, 1, 0, -8388608, 1'b0));
		cmd_q.push_back(mk_word(OP_CLICK, 1, 0, -8388608, 1'b1));
		cmd_q.push_back(mk_word(OP_CLICK, 13, 0, 100, 1'b0));
		cmd_q.push_back(mk_word(OP_EOB, 0, 0, 0, 1'b0));
		cmd_q.push_back(mk_word(OP_SAMPLE, 0, 0, 8388607, 1'b0));
		cmd_q.push_back(mk_word(OP_SAMPLE, 1, 0, -8388608, 1'b0));
		cmd_q.push_back(mk_word(OP_SAMPLE, 9, 0, 123, 1'b0));
		cmd_q.push_back(mk_word(OP_SAMPLE, 15, 15, 0, 1'b1));
		cmd_q.push_back(mk_word(OP_SAMPLE, 2, 0, -1, 1'b1));
		cmd_q.push_back(mk_word(OP_CLICK, 4, 0, -1000, 1'b0));
		cmd_q.push_back(mk_word(OP_EOB, 0, 0, 0, 1'b0));
		cmd_q.push_back(mk_word(OP_SAMPLE, 4, 0, 5000, 1'b0));
		cmd_q.push_back(mk_word(OP_SAMPLE, 4, 0, 5000, 1'b1));
		cmd_q.push_back(mk_word(OP_SAMPLE, 0, 0, 0, 1'b1));
		cmd_q.push_back(mk_word(OP_EOB, 15, 15, -1, 1'b1));
		cmd_q.push_back(mk_word(OP_COEFF, 2, 2, 16384, 1'b1));
		cmd_q.push_back(mk_word(OP_SAMPLE, 2, 0, 8388607, 1'b1));
		settle();

		for (int p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				send_idle_pct = 15;
				recv_idle_pct = 68;
			end else if (p < 7) begin
				send_idle_pct = 68;
				recv_idle_pct = 15;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			slot_bits = {$urandom, $urandom};
			if (p == 0) slot_bits = '1;
			else if (p == 1) slot_bits = '0;
			write_reg(REG_LAYOUT, CFG_DATA_W'(p < 8 ? p : $urandom_range(5)));
			write_reg(REG_KIND, CFG_DATA_W'(p % 4));
			write_reg(REG_SLOTS, slot_bits[CFG_DATA_W-1:0]);
			queue_traffic(PHASE_WORDS);
			settle();
		end

		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
